// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/mh2_pkg.sv =====
// Types and constants of the MurmurHash2 core.
`default_nettype none

package mh2_pkg;

    typedef logic [31:0] t_word;
    typedef logic [2:0]  t_nbytes;

    localparam t_word       MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;
    localparam t_word       SEED_RESET  = 32'h007b1010;

endpackage

`default_nettype wire

// ===== hw/rtl/murmur2_hash32_core.sv =====
// Streaming MurmurHash2 32-bit core: sequencer around one shared multiplier.
// Input stalls outside S_IDLE; a full word runs S_K1, S_K2, S_H, S_FOLD, a 1-3 byte tail S_TAIL, S_TFOLD.
// A last item adds finalization in S_FIN and S_FOUT; the hash is registered in S_FOUT once the output is free.
// One 32x32 multiplier, used three times per full word and once per tail or finish, sets the rate.
// Synchronous active-low reset: idle, running hash 0, seed 0x7b1010, no result pending.
`default_nettype none
`include "assert_macros.svh"

module murmur2_hash32_core (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cfg_valid,
    output logic            o_cfg_ready,
    input  mh2_pkg::t_word  i_cfg_hash_seed,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  mh2_pkg::t_word  i_data_word,
    input  mh2_pkg::t_nbytes i_bytes_valid,
    input  wire             i_first_word,
    input  wire             i_last_word,
    input  mh2_pkg::t_word  i_message_length,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    output mh2_pkg::t_word  o_hash_value
);
    import mh2_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_K1,
        S_K2,
        S_H,
        S_FOLD,
        S_TAIL,
        S_TFOLD,
        S_FIN,
        S_FOUT
    } t_state;

    t_state     r_state;
    t_word      r_seed;
    t_word      r_h;
    t_word      r_k;
    logic [1:0] r_nb;
    logic       r_last;
    t_word      r_out;
    logic       r_out_valid;

    t_word mul_op;
    t_word prod;
    t_word tail_mask;
    t_word start_h;
    logic  in_xfer;
    logic  out_xfer;
    logic  out_free;

    mh2_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .o_prod (prod)
    );

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign start_h     = i_first_word ? (r_seed ^ i_message_length) : r_h;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_hash_value = r_out;

    always_comb begin
        case (r_nb)
            2'd1:    tail_mask = 32'h000000ff;
            2'd2:    tail_mask = 32'h0000ffff;
            default: tail_mask = 32'h00ffffff;
        endcase
    end

    always_comb begin
        case (r_state)
            S_K1:        mul_op = r_k;
            S_K2:        mul_op = prod ^ (prod >> MIX_SHIFT);
            S_H:         mul_op = r_h;
            S_TAIL:      mul_op = r_h ^ (r_k & tail_mask);
            S_FIN, S_FOUT: mul_op = r_h ^ (r_h >> FIN_SHIFT_A);
            default:     mul_op = r_h;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= SEED_RESET;
            r_h         <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_hash_seed;
            end
            if (out_xfer && (r_state != S_FOUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_h    <= start_h;
                        r_k    <= i_data_word;
                        r_nb   <= i_bytes_valid[1:0];
                        r_last <= i_last_word;
                        if (i_bytes_valid[2]) begin
                            r_state <= S_K1;
                        end else if (i_bytes_valid[1:0] != 2'd0) begin
                            r_state <= S_TAIL;
                        end else if (i_last_word) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_K1: begin
                    r_state <= S_K2;
                end
                S_K2: begin
                    r_state <= S_H;
                end
                S_H: begin
                    r_k     <= prod;
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_h     <= prod ^ r_k;
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_TAIL: begin
                    r_state <= S_TFOLD;
                end
                S_TFOLD: begin
                    r_h     <= prod;
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    r_state <= S_FOUT;
                end
                S_FOUT: begin
                    if (out_free) begin
                        r_out       <= prod ^ (prod >> FIN_SHIFT_B);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_full_word_mix, i_clk, i_rst_n, in_xfer && i_bytes_valid[2], r_state == S_K1)
    `ASSERT_NEXT(a_empty_last_fin, i_clk, i_rst_n,
        in_xfer && !i_bytes_valid[2] && (i_bytes_valid[1:0] == 2'd0) && i_last_word,
        r_state == S_FIN)
    `ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, (r_state == S_FOUT) && out_free,
        o_out_valid && (r_state == S_IDLE))
    `ASSERT_IMPLIES(a_busy_in_fout, i_clk, i_rst_n, (r_state == S_FOUT) && !out_free,
        o_out_valid && i_out_stall)

endmodule

`default_nettype wire

// ===== hw/rtl/mh2_mul.sv =====
// Shared registered multiplier by the mixing constant, low 32 bits of the product.
`default_nettype none

module mh2_mul (
    input  wire           i_clk,
    input  mh2_pkg::t_word i_op,
    output mh2_pkg::t_word o_prod
);
    import mh2_pkg::*;

    t_word prod_lo;
    t_word r_prod;

    assign prod_lo = i_op * MIX_MUL;

    always_ff @(posedge i_clk) begin
        r_prod <= prod_lo;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire
